[hw/rtl/bsa_pkg.sv]
// Package for the body slot allocator: field widths, command and status codes,
// sequencer states and shared adder operations.
// No dependencies.
`timescale 1ns / 1ps

package bsa_pkg;

    localparam int MAX_BODIES_DEF  = 256;
    localparam int MAX_OBJECTS_DEF = 512;

    localparam int CMD_W    = 2;
    localparam int OBJ_W    = 9;
    localparam int BODY_W   = 8;
    localparam int SLOT_W   = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 9;
    localparam int HIGH_W   = 9;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD,
        CMD_REMOVE,
        CMD_FIND,
        CMD_RSVD
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_INACTIVE,
        ST_FULL,
        ST_NOT_FOUND,
        ST_BAD_REMOVE
    } t_status;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_POP,
        S_SCAN_INC,
        S_SCAN_CMP,
        S_ADD_WR,
        S_ADD_HIGH,
        S_RM_CHK,
        S_FIND_MAP,
        S_FIND_ACT,
        S_DONE
    } t_state;

endpackage

[hw/rtl/bsa_if.sv]
// Valid/ready channel interfaces for the body slot allocator: command in,
// result out. Depends on bsa_pkg for field widths.
`timescale 1ns / 1ps

interface bsa_in_if;
    logic                         valid;
    logic                         ready;
    logic [bsa_pkg::CMD_W-1:0]    command;
    logic [bsa_pkg::OBJ_W-1:0]    object_index;
    logic [bsa_pkg::BODY_W-1:0]   rm_slot;
    logic                         object_active;

    modport source (output valid, command, object_index, rm_slot, object_active,
                    input ready);
    modport sink   (input valid, command, object_index, rm_slot, object_active,
                    output ready);
endinterface

interface bsa_out_if;
    logic                           valid;
    logic                           ready;
    logic [bsa_pkg::SLOT_W-1:0]     slot;
    logic [bsa_pkg::STATUS_W-1:0]   status;
    logic [bsa_pkg::COUNT_W-1:0]    live_bodies;
    logic signed [bsa_pkg::HIGH_W-1:0] highest_slot;

    modport source (output valid, slot, status, live_bodies, highest_slot, input ready);
    modport sink   (input valid, slot, status, live_bodies, highest_slot, output ready);
endinterface

[hw/rtl/bsa_alu.sv]
// Shared add/subtract unit of the allocator sequencer; the subtract also gives
// a signed less-than flag. Depends on bsa_pkg for the operation codes.
`timescale 1ns / 1ps

module bsa_alu #(
    parameter int W = 10
) (
    input  bsa_pkg::t_alu_op i_op,
    input  logic [W-1:0]     i_a,
    input  logic [W-1:0]     i_b,
    output logic [W-1:0]     o_sum,
    output logic             o_lt
);

    logic [W:0] a_x;
    logic [W:0] b_x;
    logic [W:0] d;
    logic       sub;

    assign sub   = (i_op == bsa_pkg::ALU_SUB);
    assign a_x   = {i_a[W-1], i_a};
    assign b_x   = sub ? ~{i_b[W-1], i_b} : {i_b[W-1], i_b};
    // one extra bit keeps the sign of the true difference
    assign d     = a_x + b_x + (W+1)'(sub);
    assign o_sum = d[W-1:0];
    assign o_lt  = d[W];

endmodule

[hw/rtl/body_slot_allocator.sv]
// Body slot allocator: a pool of MAX_BODIES slots tied to MAX_OBJECTS objects.
// After reset the block clears its slot-active and object-map memories, one
// entry a cycle, with the input not ready until every entry of both is clear.
// It then handles one command at a time. A rejected or reserved command is
// answered from decode; a remove checks the slot's active flag; a find reads
// the object map and, for a mapped object, the slot's active flag; an add
// pops the free list or, when it is empty, checks the slot above the high
// mark against the pool size, then writes the slot and updates the high mark.
// A full output register can hold the result back. Each slot memory has a
// single read port (one registered read per step), and one shared adder does
// the count, the high-mark compare and the next-slot compare in turn. When
// the free list is empty, every slot at or below the high mark is active, so
// the first inactive slot is the one just above it. A finished result waits
// in the output register while the next command is taken.
// Depends on bsa_pkg, bsa_if.sv and bsa_alu.
`timescale 1ns / 1ps

module body_slot_allocator #(
    parameter int MAX_BODIES  = bsa_pkg::MAX_BODIES_DEF,
    parameter int MAX_OBJECTS = bsa_pkg::MAX_OBJECTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsa_in_if.sink    i_in,
    bsa_out_if.source o_out
);

    localparam int BW    = $clog2(MAX_BODIES);
    localparam int OW    = $clog2(MAX_OBJECTS);
    localparam int HW    = BW + 1;
    localparam int CW    = BW + 1;
    localparam int AW    = BW + 2;
    localparam int CLR_N = (MAX_BODIES > MAX_OBJECTS) ? MAX_BODIES : MAX_OBJECTS;
    localparam int CLR_W = $clog2(CLR_N);

    // memories
    logic          r_act_mem  [MAX_BODIES];
    logic [HW-1:0] r_link_mem [MAX_BODIES];
    logic [OW-1:0] r_own_mem  [MAX_BODIES];
    logic [BW:0]   r_map_mem  [MAX_OBJECTS];

    logic          r_act_q;
    logic [HW-1:0] r_link_q;
    logic [OW-1:0] r_own_q;
    logic [BW:0]   r_map_q;

    logic          act_we,  act_wdata;
    logic [BW-1:0] act_waddr, act_raddr;
    logic          link_we;
    logic [BW-1:0] link_waddr, link_raddr;
    logic [HW-1:0] link_wdata;
    logic          own_we;
    logic [BW-1:0] own_waddr, own_raddr;
    logic [OW-1:0] own_wdata;
    logic          map_we;
    logic [OW-1:0] map_waddr, map_raddr;
    logic [BW:0]   map_wdata;

    // sequencer and item registers
    bsa_pkg::t_state  r_state, n_state;
    logic [CLR_W-1:0] r_clr, n_clr;
    bsa_pkg::t_cmd    r_cmd, n_cmd;
    logic [bsa_pkg::OBJ_W-1:0]  r_obj, n_obj;
    logic [bsa_pkg::BODY_W-1:0] r_body, n_body;
    logic             r_objon, n_objon;
    logic             r_head_v, n_head_v;
    logic [BW-1:0]    r_head, n_head;
    logic [CW-1:0]    r_count, n_count;
    logic signed [HW-1:0] r_high, n_high;
    logic [BW-1:0]    r_slot, n_slot;
    bsa_pkg::t_status r_status, n_status;
    logic [AW-1:0]    r_tmp, n_tmp;

    // output register
    logic                          r_out_valid, n_out_valid;
    logic [bsa_pkg::SLOT_W-1:0]    r_o_slot, n_o_slot;
    bsa_pkg::t_status              r_o_status, n_o_status;
    logic [bsa_pkg::COUNT_W-1:0]   r_o_count, n_o_count;
    logic signed [bsa_pkg::HIGH_W-1:0] r_o_high, n_o_high;

    // shared adder
    bsa_pkg::t_alu_op alu_op;
    logic [AW-1:0]    alu_a, alu_b, alu_sum;
    logic             alu_lt;

    logic accept, out_free, body_ok, obj_ok;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign body_ok  = int'(r_body) < MAX_BODIES;
    assign obj_ok   = int'(r_obj) < MAX_OBJECTS;

    bsa_alu #(.W(AW)) u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_sum (alu_sum),
        .o_lt  (alu_lt)
    );

    always_ff @(posedge i_clk) begin
        if (act_we) begin
            r_act_mem[act_waddr] <= act_wdata;
        end
        r_act_q <= r_act_mem[act_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            r_link_mem[link_waddr] <= link_wdata;
        end
        r_link_q <= r_link_mem[link_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (own_we) begin
            r_own_mem[own_waddr] <= own_wdata;
        end
        r_own_q <= r_own_mem[own_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map_mem[map_waddr] <= map_wdata;
        end
        r_map_q <= r_map_mem[map_raddr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bsa_pkg::S_CLEAR: begin
                if (int'(r_clr) == CLR_N - 1) n_state = bsa_pkg::S_IDLE;
            end
            bsa_pkg::S_IDLE: begin
                if (accept) n_state = bsa_pkg::S_DECODE;
            end
            bsa_pkg::S_DECODE: begin
                unique case (r_cmd)
                    bsa_pkg::CMD_ADD: begin
                        if (!obj_ok || !r_objon) n_state = bsa_pkg::S_DONE;
                        else if (r_head_v)       n_state = bsa_pkg::S_POP;
                        else                     n_state = bsa_pkg::S_SCAN_INC;
                    end
                    bsa_pkg::CMD_REMOVE: begin
                        n_state = body_ok ? bsa_pkg::S_RM_CHK : bsa_pkg::S_DONE;
                    end
                    bsa_pkg::CMD_FIND: begin
                        n_state = obj_ok ? bsa_pkg::S_FIND_MAP : bsa_pkg::S_DONE;
                    end
                    default: n_state = bsa_pkg::S_DONE;
                endcase
            end
            bsa_pkg::S_POP:      n_state = bsa_pkg::S_ADD_WR;
            bsa_pkg::S_SCAN_INC: n_state = bsa_pkg::S_SCAN_CMP;
            bsa_pkg::S_SCAN_CMP: n_state = alu_lt ? bsa_pkg::S_ADD_WR : bsa_pkg::S_DONE;
            bsa_pkg::S_ADD_WR:   n_state = bsa_pkg::S_ADD_HIGH;
            bsa_pkg::S_ADD_HIGH: n_state = bsa_pkg::S_DONE;
            bsa_pkg::S_RM_CHK:   n_state = bsa_pkg::S_DONE;
            bsa_pkg::S_FIND_MAP: begin
                n_state = r_map_q[BW] ? bsa_pkg::S_FIND_ACT : bsa_pkg::S_DONE;
            end
            bsa_pkg::S_FIND_ACT: n_state = bsa_pkg::S_DONE;
            bsa_pkg::S_DONE: begin
                if (out_free) n_state = bsa_pkg::S_IDLE;
            end
            default: n_state = bsa_pkg::S_CLEAR;
        endcase
    end

    // datapath and memory control
    always_comb begin
        act_we     = 1'b0;
        act_waddr  = BW'(r_body);
        act_wdata  = 1'b0;
        act_raddr  = BW'(r_body);
        link_we    = 1'b0;
        link_waddr = BW'(r_body);
        link_wdata = {r_head_v, r_head};
        link_raddr = r_head;
        own_we     = 1'b0;
        own_waddr  = r_slot;
        own_wdata  = OW'(r_obj);
        own_raddr  = BW'(r_body);
        map_we     = 1'b0;
        map_waddr  = OW'(r_obj);
        map_wdata  = {1'b1, r_slot};
        map_raddr  = OW'(r_obj);

        alu_op = bsa_pkg::ALU_ADD;
        alu_a  = AW'(r_high);
        alu_b  = AW'(1);

        n_clr    = r_clr;
        n_cmd    = r_cmd;
        n_obj    = r_obj;
        n_body   = r_body;
        n_objon  = r_objon;
        n_head_v = r_head_v;
        n_head   = r_head;
        n_count  = r_count;
        n_high   = r_high;
        n_slot   = r_slot;
        n_status = r_status;
        n_tmp    = r_tmp;

        n_out_valid = r_out_valid && !o_out.ready;
        n_o_slot    = r_o_slot;
        n_o_status  = r_o_status;
        n_o_count   = r_o_count;
        n_o_high    = r_o_high;

        unique case (r_state)
            bsa_pkg::S_CLEAR: begin
                act_we    = int'(r_clr) < MAX_BODIES;
                act_waddr = BW'(r_clr);
                map_we    = int'(r_clr) < MAX_OBJECTS;
                map_waddr = OW'(r_clr);
                map_wdata = '0;
                n_clr     = CLR_W'(r_clr + 1'b1);
            end
            bsa_pkg::S_IDLE: begin
                if (accept) begin
                    n_cmd   = bsa_pkg::t_cmd'(i_in.command);
                    n_obj   = i_in.object_index;
                    n_body  = i_in.rm_slot;
                    n_objon = i_in.object_active;
                end
            end
            bsa_pkg::S_DECODE: begin
                unique case (r_cmd)
                    bsa_pkg::CMD_ADD: begin
                        if (!obj_ok || !r_objon) n_status = bsa_pkg::ST_INACTIVE;
                    end
                    bsa_pkg::CMD_REMOVE: begin
                        if (!body_ok) n_status = bsa_pkg::ST_BAD_REMOVE;
                    end
                    bsa_pkg::CMD_FIND: begin
                        if (!obj_ok) n_status = bsa_pkg::ST_NOT_FOUND;
                    end
                    default: n_status = bsa_pkg::ST_NOT_FOUND;
                endcase
            end
            bsa_pkg::S_POP: begin
                n_slot   = r_head;
                n_head_v = r_link_q[BW];
                n_head   = r_link_q[BW-1:0];
            end
            bsa_pkg::S_SCAN_INC: begin
                n_tmp = alu_sum;
            end
            bsa_pkg::S_SCAN_CMP: begin
                alu_op = bsa_pkg::ALU_SUB;
                alu_a  = r_tmp;
                alu_b  = AW'(MAX_BODIES);
                if (alu_lt) n_slot = BW'(r_tmp);
                else        n_status = bsa_pkg::ST_FULL;
            end
            bsa_pkg::S_ADD_WR: begin
                act_we    = 1'b1;
                act_waddr = r_slot;
                act_wdata = 1'b1;
                own_we    = 1'b1;
                map_we    = 1'b1;
                alu_a     = AW'(r_count);
                n_count   = CW'(alu_sum);
            end
            bsa_pkg::S_ADD_HIGH: begin
                alu_op   = bsa_pkg::ALU_SUB;
                alu_b    = AW'(r_slot);
                if (alu_lt) n_high = HW'(r_slot);
                n_status = bsa_pkg::ST_OK;
            end
            bsa_pkg::S_RM_CHK: begin
                if (r_act_q) begin
                    // deactivate, push on the free list, drop the owner's mapping
                    act_we    = 1'b1;
                    link_we   = 1'b1;
                    map_we    = 1'b1;
                    map_waddr = r_own_q;
                    map_wdata = '0;
                    n_head_v  = 1'b1;
                    n_head    = BW'(r_body);
                    alu_op    = bsa_pkg::ALU_SUB;
                    alu_a     = AW'(r_count);
                    n_count   = CW'(alu_sum);
                    n_slot    = BW'(r_body);
                    n_status  = bsa_pkg::ST_OK;
                end else begin
                    n_status = bsa_pkg::ST_BAD_REMOVE;
                end
            end
            bsa_pkg::S_FIND_MAP: begin
                act_raddr = r_map_q[BW-1:0];
                n_slot    = r_map_q[BW-1:0];
                if (!r_map_q[BW]) n_status = bsa_pkg::ST_NOT_FOUND;
            end
            bsa_pkg::S_FIND_ACT: begin
                n_status = r_act_q ? bsa_pkg::ST_OK : bsa_pkg::ST_NOT_FOUND;
            end
            bsa_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_slot    = (r_status == bsa_pkg::ST_OK) ?
                                  bsa_pkg::SLOT_W'(r_slot) : '0;
                    n_o_status  = r_status;
                    n_o_count   = bsa_pkg::COUNT_W'(r_count);
                    n_o_high    = bsa_pkg::HIGH_W'(r_high);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bsa_pkg::S_CLEAR;
            r_clr       <= '0;
            r_head_v    <= 1'b0;
            r_count     <= '0;
            r_high      <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_head_v    <= n_head_v;
            r_count     <= n_count;
            r_high      <= n_high;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_obj      <= n_obj;
        r_body     <= n_body;
        r_objon    <= n_objon;
        r_head     <= n_head;
        r_slot     <= n_slot;
        r_status   <= n_status;
        r_tmp      <= n_tmp;
        r_o_slot   <= n_o_slot;
        r_o_status <= n_o_status;
        r_o_count  <= n_o_count;
        r_o_high   <= n_o_high;
    end

    assign i_in.ready         = (r_state == bsa_pkg::S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.slot         = r_o_slot;
    assign o_out.status       = r_o_status;
    assign o_out.live_bodies  = r_o_count;
    assign o_out.highest_slot = r_o_high;

    // one command at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_in.ready)
        else $error("command accepted while another is in work");

    // a slot on the free list means the pool is not full
    a_free_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head_v |-> (int'(r_count) < MAX_BODIES))
        else $error("free list holds a slot while the pool is full");

    // every active slot lies at or below the high mark; the mark trails the
    // count by one step on an add
    a_count_vs_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != bsa_pkg::S_ADD_HIGH) |-> ((int'(r_high) + 1) >= int'(r_count)))
        else $error("live count exceeds high mark");

    // a successful remove leaves the free list non-empty
    a_push_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bsa_pkg::S_RM_CHK) && r_act_q |=> r_head_v)
        else $error("remove did not push the slot");

endmodule

[bench/body_slot_allocator_tb.sv]
// Self-checking bench for body_slot_allocator: a scripted opening, then weighted random
// add/remove/find/reserved traffic checked against an in-bench copy of the slot pool.
// Depends on bsa_pkg, bsa_if.sv and the allocator RTL.
`timescale 1ns / 1ps

module body_slot_allocator_tb;

    localparam int NB            = bsa_pkg::MAX_BODIES_DEF;
    localparam int NO            = bsa_pkg::MAX_OBJECTS_DEF;
    localparam int SCRIPT_ROWS   = 22;
    localparam int HOLD_CYCLES   = 250;
    localparam int DRAIN_CYCLES  = 32;
    localparam int TIMEOUT_NS    = 500000;

    typedef struct packed {
        logic [bsa_pkg::SLOT_W-1:0]         slot;
        bsa_pkg::t_status                   status;
        logic [bsa_pkg::COUNT_W-1:0]        count;
        logic signed [bsa_pkg::HIGH_W-1:0]  high;
    } t_pool_reply;

    typedef struct packed {
        bsa_pkg::t_cmd                cmd;
        logic [bsa_pkg::OBJ_W-1:0]    obj;
        logic [bsa_pkg::BODY_W-1:0]   body;
        logic                         act;
        logic                         typed;
        t_pool_reply                  reply;
    } t_script_row;

    logic i_clk;
    logic i_rst_n;

    bsa_in_if  cmd_if ();
    bsa_out_if res_if ();

    body_slot_allocator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (res_if)
    );

    // shadow copy of the slot pool
    bit                         slot_live [NB];
    bit                         link_ok   [NB];
    bit [bsa_pkg::BODY_W-1:0]   link_to   [NB];
    bit [bsa_pkg::OBJ_W-1:0]    owner     [NB];
    bit                         obj_bound [NO];
    bit [bsa_pkg::BODY_W-1:0]   obj_slot  [NO];
    bit                         free_ok;
    bit [bsa_pkg::BODY_W-1:0]   free_top;
    int                         live_n;
    int                         high_n;

    t_pool_reply pool_replies [$];

    int  mismatches   = 0;
    int  sent_n       = 0;
    int  checked_n    = 0;
    int  full_rejects = 0;
    int  peak_live    = 0;
    bit  hold_req     = 1'b0;
    bit  tail_run     = 1'b0;

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("body_slot_allocator_tb: done, errors");
        $finish;
    end

    function automatic t_pool_reply mk_reply(logic [bsa_pkg::SLOT_W-1:0] s,
                                             bsa_pkg::t_status st,
                                             logic [bsa_pkg::COUNT_W-1:0] n,
                                             logic signed [bsa_pkg::HIGH_W-1:0] h);
        t_pool_reply r;
        r.slot   = s;
        r.status = st;
        r.count  = n;
        r.high   = h;
        return r;
    endfunction

    function automatic t_script_row mk_row(bsa_pkg::t_cmd c, logic [bsa_pkg::OBJ_W-1:0] obj,
                                           logic [bsa_pkg::BODY_W-1:0] body, logic act,
                                           logic typed, t_pool_reply r);
        t_script_row row;
        row.cmd   = c;
        row.obj   = obj;
        row.body  = body;
        row.act   = act;
        row.typed = typed;
        row.reply = r;
        return row;
    endfunction

    function automatic t_script_row script_row(int k);
        t_pool_reply none;
        none = mk_reply('0, bsa_pkg::ST_OK, '0, '0);
        case (k)
            0:  return mk_row(bsa_pkg::CMD_FIND,   9'd0,   8'd0,   1'b1, 1'b1,
                              mk_reply(8'd0, bsa_pkg::ST_NOT_FOUND, 9'd0, -9'sd1));
            1:  return mk_row(bsa_pkg::CMD_REMOVE, 9'd0,   8'd0,   1'b1, 1'b1,
                              mk_reply(8'd0, bsa_pkg::ST_BAD_REMOVE, 9'd0, -9'sd1));
            2:  return mk_row(bsa_pkg::CMD_ADD,    9'd511, 8'd0,   1'b0, 1'b1,
                              mk_reply(8'd0, bsa_pkg::ST_INACTIVE, 9'd0, -9'sd1));
            3:  return mk_row(bsa_pkg::CMD_RSVD,   9'd511, 8'd255, 1'b1, 1'b1,
                              mk_reply(8'd0, bsa_pkg::ST_NOT_FOUND, 9'd0, -9'sd1));
            4:  return mk_row(bsa_pkg::CMD_ADD,    9'd0,   8'd0,   1'b1, 1'b1,
                              mk_reply(8'd0, bsa_pkg::ST_OK, 9'd1, 9'sd0));
            5:  return mk_row(bsa_pkg::CMD_ADD,    9'd511, 8'd0,   1'b1, 1'b1,
                              mk_reply(8'd1, bsa_pkg::ST_OK, 9'd2, 9'sd1));
            // remap object 0; its old slot stays live
            6:  return mk_row(bsa_pkg::CMD_ADD,    9'd0,   8'd0,   1'b1, 1'b0, none);
            7:  return mk_row(bsa_pkg::CMD_FIND,   9'd0,   8'd0,   1'b0, 1'b0, none);
            8:  return mk_row(bsa_pkg::CMD_FIND,   9'd511, 8'd0,   1'b0, 1'b0, none);
            9:  return mk_row(bsa_pkg::CMD_REMOVE, 9'd0,   8'd2,   1'b0, 1'b0, none);
            10: return mk_row(bsa_pkg::CMD_FIND,   9'd0,   8'd0,   1'b1, 1'b0, none);
            // old slot of a remapped owner
            11: return mk_row(bsa_pkg::CMD_REMOVE, 9'd0,   8'd0,   1'b0, 1'b0, none);
            12: return mk_row(bsa_pkg::CMD_REMOVE, 9'd0,   8'd0,   1'b1, 1'b0, none);
            // two pops from the free list, then a fresh slot
            13: return mk_row(bsa_pkg::CMD_ADD,    9'd5,   8'd0,   1'b1, 1'b0, none);
            14: return mk_row(bsa_pkg::CMD_ADD,    9'd6,   8'd0,   1'b1, 1'b0, none);
            15: return mk_row(bsa_pkg::CMD_ADD,    9'd7,   8'd0,   1'b1, 1'b0, none);
            16: return mk_row(bsa_pkg::CMD_REMOVE, 9'd0,   8'd255, 1'b1, 1'b0, none);
            17: return mk_row(bsa_pkg::CMD_RSVD,   9'd0,   8'd0,   1'b0, 1'b0, none);
            18: return mk_row(bsa_pkg::CMD_FIND,   9'd256, 8'd0,   1'b1, 1'b0, none);
            19: return mk_row(bsa_pkg::CMD_ADD,    9'd170, 8'h55,  1'b1, 1'b0, none);
            20: return mk_row(bsa_pkg::CMD_REMOVE, 9'h1ff, 8'd1,   1'b0, 1'b0, none);
            default: return mk_row(bsa_pkg::CMD_FIND, 9'd511, 8'd0, 1'b1, 1'b0, none);
        endcase
    endfunction

    // Apply one command to the shadow pool and return the reply it should give.
    function automatic t_pool_reply apply_pool_cmd(bsa_pkg::t_cmd c,
                                                   bit [bsa_pkg::OBJ_W-1:0] obj,
                                                   bit [bsa_pkg::BODY_W-1:0] body, bit act);
        t_pool_reply r;
        int          s;
        int          i;
        bit          got;
        r.slot   = '0;
        r.status = bsa_pkg::ST_NOT_FOUND;
        s        = 0;
        got      = 1'b0;
        case (c)
            bsa_pkg::CMD_ADD: begin
                if (!act) begin
                    r.status = bsa_pkg::ST_INACTIVE;
                end else begin
                    if (free_ok) begin
                        s        = int'(free_top);
                        free_ok  = link_ok[s];
                        free_top = link_to[s];
                        got      = 1'b1;
                    end else begin
                        for (i = 0; i < NB; i++) begin
                            if (!got && !slot_live[i]) begin
                                s   = i;
                                got = 1'b1;
                            end
                        end
                    end
                    if (!got) begin
                        r.status = bsa_pkg::ST_FULL;
                        full_rejects++;
                    end else begin
                        slot_live[s] = 1'b1;
                        link_ok[s]   = 1'b0;
                        link_to[s]   = '0;
                        owner[s]     = obj;
                        live_n++;
                        if (s > high_n) high_n = s;
                        obj_bound[obj] = 1'b1;
                        obj_slot[obj]  = bsa_pkg::BODY_W'(s);
                        r.slot   = bsa_pkg::SLOT_W'(s);
                        r.status = bsa_pkg::ST_OK;
                    end
                end
            end
            bsa_pkg::CMD_REMOVE: begin
                if (!slot_live[body]) begin
                    r.status = bsa_pkg::ST_BAD_REMOVE;
                end else begin
                    obj_bound[owner[body]] = 1'b0;
                    slot_live[body] = 1'b0;
                    link_ok[body]   = free_ok;
                    link_to[body]   = free_top;
                    free_ok         = 1'b1;
                    free_top        = body;
                    live_n--;
                    r.slot   = body;
                    r.status = bsa_pkg::ST_OK;
                end
            end
            bsa_pkg::CMD_FIND: begin
                if (obj_bound[obj] && slot_live[obj_slot[obj]]) begin
                    r.slot   = obj_slot[obj];
                    r.status = bsa_pkg::ST_OK;
                end
            end
            default: ;
        endcase
        if (live_n > peak_live) peak_live = live_n;
        r.count = live_n[bsa_pkg::COUNT_W-1:0];
        r.high  = high_n[bsa_pkg::HIGH_W-1:0];
        return r;
    endfunction

    // Offer one transaction and hold it until the block takes it.
    task automatic send_cmd(input bsa_pkg::t_cmd c, input bit [bsa_pkg::OBJ_W-1:0] obj,
                            input bit [bsa_pkg::BODY_W-1:0] body, input bit act,
                            input bit typed, input t_pool_reply typed_reply);
        t_pool_reply r;
        cmd_if.valid         <= 1'b1;
        cmd_if.command       <= c;
        cmd_if.object_index  <= obj;
        cmd_if.rm_slot       <= body;
        cmd_if.object_active <= act;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        r = apply_pool_cmd(c, obj, body, act);
        pool_replies.push_back(typed ? typed_reply : r);
        sent_n++;
    endtask

    task automatic idle_gap(input int gap_pct);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    task automatic send_random(input int add_pct, input int rm_pct, input int find_pct);
        int                         roll;
        int                         start;
        int                         i;
        bit [bsa_pkg::OBJ_W-1:0]    obj;
        bit [bsa_pkg::BODY_W-1:0]   body;
        bit                         act;
        bit                         hit;
        bsa_pkg::t_cmd              c;
        roll = $urandom_range(0, 99);
        obj  = bsa_pkg::OBJ_W'($urandom_range(0, NO - 1));
        body = bsa_pkg::BODY_W'($urandom_range(0, NB - 1));
        act  = ($urandom_range(0, 9) != 0);
        hit  = 1'b0;
        if (roll < add_pct) begin
            c = bsa_pkg::CMD_ADD;
        end else if (roll < add_pct + rm_pct) begin
            c = bsa_pkg::CMD_REMOVE;
            // aim most removes at a live slot
            if ($urandom_range(0, 99) < 85) begin
                start = $urandom_range(0, NB - 1);
                for (i = 0; i < NB; i++) begin
                    if (!hit && slot_live[(start + i) % NB]) begin
                        body = bsa_pkg::BODY_W'((start + i) % NB);
                        hit  = 1'b1;
                    end
                end
            end
        end else if (roll < add_pct + rm_pct + find_pct) begin
            c = bsa_pkg::CMD_FIND;
            // aim most finds at a mapped object
            if ($urandom_range(0, 99) < 75) begin
                start = $urandom_range(0, NO - 1);
                for (i = 0; i < NO; i++) begin
                    if (!hit && obj_bound[(start + i) % NO]) begin
                        obj = bsa_pkg::OBJ_W'((start + i) % NO);
                        hit = 1'b1;
                    end
                end
            end
        end else begin
            c = bsa_pkg::CMD_RSVD;
        end
        send_cmd(c, obj, body, act, 1'b0, '0);
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] seen);
        if (want !== seen) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
        end
    endtask

    // compare every accepted result with the oldest outstanding reply
    always @(posedge i_clk) begin : reply_check
        t_pool_reply want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pool_replies.size() == 0) begin
                mismatches++;
                $display("%0t: result with nothing outstanding, slot %0d status %0d",
                         $time, res_if.slot, res_if.status);
            end else begin
                want = pool_replies.pop_front();
                check_field("slot",         32'(want.slot),   32'(res_if.slot));
                check_field("status",       32'(want.status), 32'(res_if.status));
                check_field("live_bodies",  32'(want.count),  32'(res_if.live_bodies));
                check_field("highest_slot", 32'(want.high),   32'(res_if.highest_slot));
                checked_n++;
            end
        end
    end

    initial begin : sink_side
        int stall;
        int span;
        bit calm;
        stall = 0;
        span  = 0;
        calm  = 1'b0;
        res_if.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (span == 0) begin
                calm = ($urandom_range(0, 3) == 0);
                span = $urandom_range(100, 300);
            end
            span--;
            if (hold_req) begin
                hold_req = 1'b0;
                stall    = HOLD_CYCLES;
            end else if (!tail_run && !calm && stall == 0 && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 11);
            end
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                stall--;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin : source_side
        t_script_row row;
        int          k;
        for (k = 0; k < NB; k++) begin
            slot_live[k] = 1'b0;
            link_ok[k]   = 1'b0;
            link_to[k]   = '0;
            owner[k]     = '0;
        end
        for (k = 0; k < NO; k++) begin
            obj_bound[k] = 1'b0;
            obj_slot[k]  = '0;
        end
        free_ok  = 1'b0;
        free_top = '0;
        live_n   = 0;
        high_n   = -1;

        i_rst_n              <= 1'b0;
        cmd_if.valid         <= 1'b0;
        cmd_if.command       <= bsa_pkg::CMD_ADD;
        cmd_if.object_index  <= '0;
        cmd_if.rm_slot       <= '0;
        cmd_if.object_active <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < SCRIPT_ROWS; k++) begin
            row = script_row(k);
            send_cmd(row.cmd, row.obj, row.body, row.act, row.typed, row.reply);
            idle_gap(30);
        end

        // mixed traffic; request the long output hold-off midway
        for (k = 0; k < 300; k++) begin
            if (k == 150) hold_req = 1'b1;
            send_random(45, 25, 25);
            idle_gap((k / 50) % 2 == 0 ? 25 : 0);
        end
        // fill the pool past full
        for (k = 0; k < 400; k++) begin
            send_random(80, 5, 13);
            idle_gap(15);
        end
        // drain it back down
        for (k = 0; k < 350; k++) begin
            send_random(10, 70, 17);
            idle_gap(20);
        end
        for (k = 0; k < 330; k++) begin
            send_random(40, 30, 25);
            idle_gap((k / 60) % 2 == 0 ? 0 : 30);
        end
        // back-to-back tail, no idling on either side
        tail_run = 1'b1;
        for (k = 0; k < 150; k++) begin
            send_random(45, 30, 22);
        end
        cmd_if.valid <= 1'b0;

        while (pool_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d commands sent, %0d results checked, peak of %0d live bodies",
                 sent_n, checked_n, peak_live);
        $display("summary: %0d pool-full rejects, highest slot reached %0d",
                 full_rejects, high_n);
        if (mismatches == 0) begin
            $display("body_slot_allocator_tb: done, clean");
        end else begin
            $display("body_slot_allocator_tb: done, errors");
        end
        $finish;
    end

endmodule
